// ===== sv/rorl_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes, result record type and character helpers for the relocating
// object record loader. No dependencies.
package rorl_pkg;

  // request function codes (s_axis_tuser)
  localparam logic [1:0] FUNC_CHAR = 2'd0;
  localparam logic [1:0] FUNC_EOS  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // result kinds (m_axis_tuser)
  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_EOS    = 2'd2;

  // status codes
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_NO_HEADER = 3'd1;
  localparam logic [2:0] ST_NO_END    = 3'd2;
  localparam logic [2:0] ST_COMPLETE  = 3'd3;
  localparam logic [2:0] ST_IGNORED   = 3'd4;

  // record types
  localparam logic [2:0] REC_H     = 3'd0;
  localparam logic [2:0] REC_T     = 3'd1;
  localparam logic [2:0] REC_M     = 3'd2;
  localparam logic [2:0] REC_E     = 3'd3;
  localparam logic [2:0] REC_OTHER = 3'd4;

  // load phases
  localparam logic [1:0] PHASE_EXPECT = 2'd0;
  localparam logic [1:0] PHASE_LOAD   = 2'd1;
  localparam logic [1:0] PHASE_DONE   = 2'd2;
  localparam logic [1:0] PHASE_BAD    = 2'd3;

  // characters
  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_H  = 8'h48;
  localparam logic [7:0] CHAR_T  = 8'h54;
  localparam logic [7:0] CHAR_M  = 8'h4D;
  localparam logic [7:0] CHAR_E  = 8'h45;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] read_data;
    logic [2:0] record_kind;
    logic [2:0] status;
  } res_t;

  // non-hex characters read as zero
  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] d;
    d = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch[3:0];
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      d = ch[3:0] + 4'd9;
    end
    return d;
  endfunction

  function automatic logic [2:0] type_code(input logic [7:0] ch);
    logic [2:0] k;
    k = REC_OTHER;
    if (ch == CHAR_H) k = REC_H;
    else if (ch == CHAR_T) k = REC_T;
    else if (ch == CHAR_M) k = REC_M;
    else if (ch == CHAR_E) k = REC_E;
    return k;
  endfunction

  // mask of the low n half-bytes, n = 1..6
  function automatic logic [23:0] digit_mask(input logic [2:0] n);
    logic [23:0] m;
    case (n)
      3'd1:    m = 24'h00000F;
      3'd2:    m = 24'h0000FF;
      3'd3:    m = 24'h000FFF;
      3'd4:    m = 24'h00FFFF;
      3'd5:    m = 24'h0FFFFF;
      3'd6:    m = 24'hFFFFFF;
      default: m = 24'h000000;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/relocating_object_record_loader_unit.sv =====
`timescale 1ns / 1ps
// Relocating object record loader: parses object text into a byte store.
// Depends on rorl_pkg and rorl_ram.
//
// channel   dir  payload (low bit first)                      transfer
// s_axis    in   tdata: char_in[7:0], read_addr[22:8]; tuser: func  tvalid & tready
// m_axis    out  tdata: status, record_kind, read_data; tuser: kind tvalid & tready
// cfg       in   cfg_wr_data_i: program_base                    cfg_wr_en_i
//
// Sequencing: an ordinary character is handled in S_IDLE (at most one store
//   write); end of stream and newline go on to S_PUT, a read to S_RDW (the
//   RAM read is registered) and then S_PUT. A modification record's newline
//   first walks nb = ceil(length/2) bytes on the single RAM port: nb
//   read/capture pairs, one add, nb writes. Reset: a clearing pass zeroes
//   every word of the store; no request is taken meanwhile, config writes are.
// Stalls: a finished result sits in the output register; input is taken
//   meanwhile and only a further result waits for the register to drain.
module relocating_object_record_loader_unit #(
  parameter int MEM_ADDR_BITS = 15,
  parameter int MAX_LINE      = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [14:0] cfg_wr_data_i,   // program_base
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // char_in[7:0], read_addr[22:8], zero pad
  input  logic [1:0]  s_axis_tuser,    // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // status[2:0], record_kind[5:3], read_data[13:6]
  output logic [1:0]  m_axis_tuser     // kind
);

  localparam int AW       = MEM_ADDR_BITS;
  localparam int MemDepth = 2 ** MEM_ADDR_BITS;
  localparam int CW       = $clog2(MAX_LINE + 1);
  localparam logic [CW-1:0] ColLimit = CW'(MAX_LINE);

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;  // clearing pass
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RDW  = 3'd2;  // read data on its way
  localparam logic [2:0] S_MRD  = 3'd3;  // modification: read byte
  localparam logic [2:0] S_MCAP = 3'd4;  // modification: capture byte
  localparam logic [2:0] S_MADD = 3'd5;  // modification: relocate
  localparam logic [2:0] S_MWR  = 3'd6;  // modification: write back
  localparam logic [2:0] S_PUT  = 3'd7;  // hand result to output register

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [14:0]   pb_q;

  // line state
  logic [2:0]    line_type_q, line_type_d;
  logic [CW-1:0] column_q, column_d;
  logic [AW-1:0] faddr_q, faddr_d;
  logic [7:0]    flen_q, flen_d;
  logic [3:0]    hnib_q, hnib_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [7:0]    bdone_q, bdone_d;
  logic [1:0]    phase_q, phase_d;

  // modification working registers
  logic [AW-1:0] m_addr_q, m_addr_d;
  logic [2:0]    m_n_q, m_n_d;
  logic [1:0]    m_idx_q, m_idx_d;
  logic [23:0]   m_val_q, m_val_d;
  logic [1:0]    m_nb, m_last;
  logic [23:0]   m_sum, m_mask;

  rorl_pkg::res_t res_q, res_d;
  rorl_pkg::res_t out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic       accept;
  logic [1:0] in_func;
  logic [7:0] in_char;
  logic [14:0] in_raddr;
  logic [3:0] digit;
  logic [2:0] rec_now;

  assign in_func  = s_axis_tuser;
  assign in_char  = s_axis_tdata[7:0];
  assign in_raddr = s_axis_tdata[22:8];
  assign digit    = rorl_pkg::hex_value(in_char);
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;

  // an empty line counts as an unknown record
  assign rec_now = (column_q == '0) ? rorl_pkg::REC_OTHER : line_type_q;

  assign m_nb   = 2'((m_n_q + 3'd1) >> 1);
  assign m_last = m_nb - 2'd1;
  assign m_sum  = m_val_q + 24'(pb_q);
  assign m_mask = rorl_pkg::digit_mask(m_n_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {2'b00, out_q.read_data, out_q.record_kind, out_q.status};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    line_type_d = line_type_q;
    column_d    = column_q;
    faddr_d     = faddr_q;
    flen_d      = flen_q;
    hnib_d      = hnib_q;
    wp_d        = wp_q;
    bdone_d     = bdone_q;
    phase_d     = phase_q;
    m_addr_d    = m_addr_q;
    m_n_d       = m_n_q;
    m_idx_d     = m_idx_q;
    m_val_d     = m_val_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            rorl_pkg::FUNC_CHAR: begin
              if (in_char != rorl_pkg::CHAR_NL) begin
                // characters beyond the line limit are dropped
                if (column_q < ColLimit) begin
                  column_d = column_q + CW'(1);
                  if (column_q == '0) begin
                    line_type_d = rorl_pkg::type_code(in_char);
                  end else if (column_q <= CW'(6)) begin
                    faddr_d = {faddr_q[AW-5:0], digit};
                  end else if (column_q <= CW'(8)) begin
                    flen_d = {flen_q[3:0], digit};
                    if (column_q == CW'(8)) begin
                      wp_d = faddr_q + AW'(pb_q);
                    end
                  end else if (column_q[0]) begin
                    hnib_d = digit;
                  end else if (phase_q == rorl_pkg::PHASE_LOAD &&
                               line_type_q == rorl_pkg::REC_T &&
                               bdone_q < flen_q) begin
                    ram_we    = 1'b1;
                    ram_addr  = wp_q;
                    ram_wdata = {hnib_q, digit};
                    wp_d      = wp_q + AW'(1);
                    bdone_d   = bdone_q + 8'd1;
                  end
                end
              end else begin
                res_d             = '0;
                res_d.kind        = rorl_pkg::KIND_RECORD;
                res_d.record_kind = rec_now;
                res_d.status      = rorl_pkg::ST_IGNORED;
                state_d           = S_PUT;
                unique case (phase_q)
                  rorl_pkg::PHASE_EXPECT: begin
                    if (rec_now == rorl_pkg::REC_H) begin
                      res_d.status = rorl_pkg::ST_ACCEPTED;
                      phase_d      = rorl_pkg::PHASE_LOAD;
                    end else begin
                      res_d.status = rorl_pkg::ST_NO_HEADER;
                      phase_d      = rorl_pkg::PHASE_BAD;
                    end
                  end
                  rorl_pkg::PHASE_LOAD: begin
                    if (rec_now == rorl_pkg::REC_E) begin
                      res_d.status = rorl_pkg::ST_COMPLETE;
                      phase_d      = rorl_pkg::PHASE_DONE;
                    end else if (rec_now == rorl_pkg::REC_T) begin
                      res_d.status = rorl_pkg::ST_ACCEPTED;
                    end else if (rec_now == rorl_pkg::REC_M &&
                                 flen_q >= 8'd1 && flen_q <= 8'd6) begin
                      res_d.status = rorl_pkg::ST_ACCEPTED;
                      m_addr_d     = faddr_q + AW'(pb_q);
                      m_n_d        = flen_q[2:0];
                      m_idx_d      = '0;
                      m_val_d      = '0;
                      state_d      = S_MRD;
                    end
                  end
                  default: ;
                endcase
                line_type_d = rorl_pkg::REC_OTHER;
                column_d    = '0;
                faddr_d     = '0;
                flen_d      = '0;
                hnib_d      = '0;
                wp_d        = '0;
                bdone_d     = '0;
              end
            end

            rorl_pkg::FUNC_EOS: begin
              res_d      = '0;
              res_d.kind = rorl_pkg::KIND_EOS;
              unique case (phase_q)
                rorl_pkg::PHASE_DONE: res_d.status = rorl_pkg::ST_COMPLETE;
                rorl_pkg::PHASE_BAD:  res_d.status = rorl_pkg::ST_NO_HEADER;
                rorl_pkg::PHASE_LOAD: begin
                  res_d.status = (rec_now == rorl_pkg::REC_E) ?
                                 rorl_pkg::ST_COMPLETE : rorl_pkg::ST_NO_END;
                end
                default: begin
                  res_d.status = (rec_now == rorl_pkg::REC_H) ?
                                 rorl_pkg::ST_NO_END : rorl_pkg::ST_NO_HEADER;
                end
              endcase
              line_type_d = rorl_pkg::REC_OTHER;
              column_d    = '0;
              faddr_d     = '0;
              flen_d      = '0;
              hnib_d      = '0;
              wp_d        = '0;
              bdone_d     = '0;
              phase_d     = rorl_pkg::PHASE_EXPECT;
              state_d     = S_PUT;
            end

            rorl_pkg::FUNC_READ: begin
              ram_addr   = AW'(in_raddr);
              res_d      = '0;
              res_d.kind = rorl_pkg::KIND_READ;
              state_d    = S_RDW;
            end

            default: ;
          endcase
        end
      end

      S_RDW: begin
        res_d.read_data = ram_rdata;
        state_d         = S_PUT;
      end

      S_MRD: begin
        ram_addr = m_addr_q + AW'(m_idx_q);
        state_d  = S_MCAP;
      end

      S_MCAP: begin
        // big-endian: first byte ends up on top
        m_val_d = {m_val_q[15:0], ram_rdata};
        if (m_idx_q == m_last) begin
          state_d = S_MADD;
        end else begin
          m_idx_d = m_idx_q + 2'd1;
          state_d = S_MRD;
        end
      end

      S_MADD: begin
        m_val_d = (m_val_q & ~m_mask) | (m_sum & m_mask);
        state_d = S_MWR;
      end

      S_MWR: begin
        // write back from the last byte down
        ram_we    = 1'b1;
        ram_addr  = m_addr_q + AW'(m_idx_q);
        ram_wdata = m_val_q[7:0];
        m_val_d   = m_val_q >> 8;
        if (m_idx_q == 2'd0) begin
          state_d = S_PUT;
        end else begin
          m_idx_d = m_idx_q - 2'd1;
        end
      end

      S_PUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      pb_q        <= '0;
      line_type_q <= rorl_pkg::REC_H;
      column_q    <= '0;
      faddr_q     <= '0;
      flen_q      <= '0;
      hnib_q      <= '0;
      wp_q        <= '0;
      bdone_q     <= '0;
      phase_q     <= rorl_pkg::PHASE_EXPECT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      if (cfg_wr_en_i) begin
        pb_q <= cfg_wr_data_i;
      end
      line_type_q <= line_type_d;
      column_q    <= column_d;
      faddr_q     <= faddr_d;
      flen_q      <= flen_d;
      hnib_q      <= hnib_d;
      wp_q        <= wp_d;
      bdone_q     <= bdone_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_addr_q <= m_addr_d;
    m_n_q    <= m_n_d;
    m_idx_q  <= m_idx_d;
    m_val_q  <= m_val_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  rorl_ram #(
    .WIDTH(8),
    .DEPTH(MemDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // store writes only from the clearing pass, a T data pair or write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLR || state_q == S_IDLE || state_q == S_MWR))
    else $error("store write outside a writing state");

  // modification walk stays inside its field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MRD || state_q == S_MCAP || state_q == S_MWR) |->
      (m_n_q >= 3'd1 && m_n_q <= 3'd6 && m_idx_q <= m_last))
    else $error("modification index out of range");

  // results enter the output register only from the hand-over state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_PUT))
    else $error("result loaded outside hand-over");

  // leaving the header phase needs a finished line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rorl_pkg::PHASE_EXPECT && phase_d != rorl_pkg::PHASE_EXPECT) |->
      (accept && in_func == rorl_pkg::FUNC_CHAR && in_char == rorl_pkg::CHAR_NL))
    else $error("header phase left without a newline");

endmodule

// ===== sv/rorl_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM, registered read; a read during a write returns the old word.
// No dependencies.
module rorl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== test/rorl_load_checker.sv =====
`timescale 1ns / 1ps
// Checker for the relocating object record loader: predicts each result and compares.
// Watches the request, result and config channels. Depends on rorl_pkg.
module rorl_load_checker
  import rorl_pkg::*;
#(
  parameter int LINE_LIMIT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [14:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int          STORE_BITS  = 15;
  localparam int          STORE_DEPTH = 1 << STORE_BITS;
  localparam logic [7:0]  GLYPH_0     = "0";
  localparam logic [7:0]  GLYPH_9     = "9";
  localparam logic [7:0]  GLYPH_UA    = "A";
  localparam logic [7:0]  GLYPH_UF    = "F";
  localparam logic [7:0]  GLYPH_LA    = "a";
  localparam logic [7:0]  GLYPH_LF    = "f";

  logic [7:0]            image_mem [STORE_DEPTH];
  logic [2:0]            cur_type;
  int unsigned           col;
  logic [23:0]           rec_addr;
  logic [7:0]            rec_len;
  logic [3:0]            pend_nib;
  logic [STORE_BITS-1:0] store_ptr;
  logic [7:0]            stored_cnt;
  logic [1:0]            phase;
  logic [14:0]           base;
  res_t                  awaited_q[$];
  int                    errors;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [3:0] nibble_of(logic [7:0] ch);
    logic [3:0] d;
    d = 4'd0;
    if (ch >= GLYPH_0 && ch <= GLYPH_9) d = 4'(ch - GLYPH_0);
    else if (ch >= GLYPH_UA && ch <= GLYPH_UF) d = 4'(ch - GLYPH_UA + 8'd10);
    else if (ch >= GLYPH_LA && ch <= GLYPH_LF) d = 4'(ch - GLYPH_LA + 8'd10);
    return d;
  endfunction

  function automatic logic [2:0] rec_type_of(logic [7:0] ch);
    logic [2:0] k;
    case (ch)
      CHAR_H:  k = REC_H;
      CHAR_T:  k = REC_T;
      CHAR_M:  k = REC_M;
      CHAR_E:  k = REC_E;
      default: k = REC_OTHER;
    endcase
    return k;
  endfunction

  function automatic void reset_line();
    cur_type   = REC_OTHER;
    col        = 0;
    rec_addr   = '0;
    rec_len    = '0;
    pend_nib   = '0;
    store_ptr  = '0;
    stored_cnt = '0;
  endfunction

  function automatic void absorb_char(logic [7:0] ch);
    int unsigned c;
    logic [3:0]  d;
    c = col;
    d = nibble_of(ch);
    if (c < LINE_LIMIT) begin
      col = c + 1;
      if (c == 0) begin
        cur_type = rec_type_of(ch);
      end else if (c <= 6) begin
        rec_addr = {rec_addr[19:0], d};
      end else if (c <= 8) begin
        rec_len = {rec_len[3:0], d};
        if (c == 8) store_ptr = STORE_BITS'(rec_addr + base);
      end else if (((c - 9) & 1) == 0) begin
        pend_nib = d;
      end else if (phase == PHASE_LOAD && cur_type == REC_T && stored_cnt < rec_len) begin
        image_mem[store_ptr] = {pend_nib, d};
        store_ptr  = store_ptr + 1'b1;
        stored_cnt = stored_cnt + 1'b1;
      end
    end
  endfunction

  // relocate the low rec_len nibbles of a big-endian field in place
  function automatic bit patch_field();
    int unsigned           n, nb, i;
    logic [STORE_BITS-1:0] a;
    logic [31:0]           v, m;
    n = rec_len;
    if (n < 1 || n > 6) return 1'b0;
    nb = (n + 1) / 2;
    a  = STORE_BITS'(rec_addr + base);
    v  = '0;
    for (i = 0; i < nb; i++) v = (v << 8) | image_mem[STORE_BITS'(a + i)];
    m = (32'd1 << (4 * n)) - 32'd1;
    v = (v & ~m) | ((v + base) & m);
    for (i = nb; i > 0; i--) begin
      image_mem[STORE_BITS'(a + i - 1)] = v[7:0];
      v = v >> 8;
    end
    return 1'b1;
  endfunction

  function automatic res_t close_line();
    logic [2:0] k, st;
    res_t       r;
    k  = (col == 0) ? REC_OTHER : cur_type;
    st = ST_IGNORED;
    case (phase)
      PHASE_EXPECT: begin
        if (k == REC_H) begin
          st    = ST_ACCEPTED;
          phase = PHASE_LOAD;
        end else begin
          st    = ST_NO_HEADER;
          phase = PHASE_BAD;
        end
      end
      PHASE_LOAD: begin
        if (k == REC_E) begin
          st    = ST_COMPLETE;
          phase = PHASE_DONE;
        end else if (k == REC_T) begin
          st = ST_ACCEPTED;
        end else if (k == REC_M) begin
          st = patch_field() ? ST_ACCEPTED : ST_IGNORED;
        end
      end
      default: ;
    endcase
    reset_line();
    r             = '0;
    r.kind        = KIND_RECORD;
    r.status      = st;
    r.record_kind = k;
    return r;
  endfunction

  function automatic res_t end_of_stream();
    logic [2:0] k, st;
    res_t       r;
    k = (col == 0) ? REC_OTHER : cur_type;
    case (phase)
      PHASE_DONE: st = ST_COMPLETE;
      PHASE_BAD:  st = ST_NO_HEADER;
      PHASE_LOAD: st = (k == REC_E) ? ST_COMPLETE : ST_NO_END;
      default:    st = (k == REC_H) ? ST_NO_END : ST_NO_HEADER;
    endcase
    reset_line();
    phase    = PHASE_EXPECT;
    r        = '0;
    r.kind   = KIND_EOS;
    r.status = st;
    return r;
  endfunction

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t       r;
    logic [7:0] ch;
    if (!rst_ni) begin
      foreach (image_mem[i]) image_mem[i] = '0;
      reset_line();
      cur_type = REC_H;
      phase    = PHASE_EXPECT;
      base     = '0;
      awaited_q.delete();
      errors   = 0;
    end else begin
      if (cfg_wr_en_i) base = cfg_wr_data_i;
      // predict first, so an answer accepted alongside its request would still find its entry
      if (s_axis_tvalid && s_axis_tready) begin
        ch = s_axis_tdata[7:0];
        case (s_axis_tuser)
          FUNC_CHAR: begin
            if (ch == CHAR_NL) awaited_q.push_back(close_line());
            else absorb_char(ch);
          end
          FUNC_EOS: awaited_q.push_back(end_of_stream());
          FUNC_READ: begin
            r           = '0;
            r.kind      = KIND_READ;
            r.read_data = image_mem[s_axis_tdata[22:8]];
            awaited_q.push_back(r);
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_q.size() == 0) begin
          $error("result with nothing outstanding: kind %0d tdata %h",
                 m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          r = awaited_q.pop_front();
          check_field("kind", r.kind, m_axis_tuser);
          check_field("status", r.status, m_axis_tdata[2:0]);
          check_field("record_kind", r.record_kind, m_axis_tdata[5:3]);
          check_field("read_data", r.read_data, m_axis_tdata[13:6]);
        end
      end
    end
    fail_count_o <= errors;
    pending_o    <= awaited_q.size();
  end

endmodule

// ===== test/relocating_object_record_loader_unit_tb.sv =====
`timescale 1ns / 1ps
// Top of the loader testbench: clock, reset, object text stimulus and verdict.
// Depends on rorl_pkg, relocating_object_record_loader_unit and rorl_load_checker.
module relocating_object_record_loader_unit_tb;
  import rorl_pkg::*;

  // request code with no effect on the block, absent from the package
  localparam logic [1:0] FUNC_NONE   = 2'd3;
  // covers the store clearing pass after reset with margin
  localparam int         WATCH_LIMIT = 120000;
  // quiet cycles after the last result, before a config write or the verdict
  localparam int         SETTLE      = 24;
  localparam int         PHASE_ITEMS = 275;
  localparam logic [7:0] GLYPH_0     = "0";
  localparam logic [7:0] GLYPH_UA    = "A";
  localparam logic [7:0] GLYPH_LA    = "a";
  localparam logic [7:0] GLYPH_G     = "G";

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_wr_en_i   = 1'b0;
  logic [14:0] cfg_wr_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = FUNC_CHAR;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int          fail_count;
  int          pending;
  int          tx_idle_pct = 20;
  int          rx_idle_pct = 46;
  int          items_sent  = 0;
  int          quiet_cycles = 0;
  logic [14:0] cur_base    = '0;
  logic [7:0]  text_q[$];

  relocating_object_record_loader_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  rorl_load_checker load_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog: ends the run once nothing has moved on either channel for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCH_LIMIT) begin
      $display("relocating_object_record_loader_unit_tb NOT OK");
      $finish;
    end
  end

  // one request; valid stays up across back-to-back requests
  task automatic push_request(logic [1:0] f, logic [7:0] ch, logic [14:0] ra);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, ra, ch};
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (f != FUNC_NONE) items_sent++;
  endtask

  task automatic send_eos();
    push_request(FUNC_EOS, 8'($urandom), 15'($urandom));
  endtask

  // mostly near the current load area so reads see written bytes
  task automatic read_probe();
    logic [14:0] a;
    if ($urandom_range(99) < 70) a = cur_base + 15'($urandom_range(240));
    else a = 15'($urandom);
    push_request(FUNC_READ, 8'($urandom), a);
  endtask

  task automatic idle_request();
    push_request(FUNC_NONE, 8'($urandom), 15'($urandom));
  endtask

  // hex digit in either case, now and then a non-hex letter (reads as zero)
  function automatic logic [7:0] hex_glyph(logic [3:0] d);
    int r;
    r = $urandom_range(99);
    if (r < 2) return GLYPH_G + 8'($urandom_range(19));
    if (d < 4'd10) return GLYPH_0 + 8'(d);
    if (r < 50) return GLYPH_UA + 8'(d) - 8'd10;
    return GLYPH_LA + 8'(d) - 8'd10;
  endfunction

  task automatic put_hex(logic [23:0] v, int n);
    for (int i = n - 1; i >= 0; i--) text_q.push_back(hex_glyph(v[4*i +: 4]));
  endtask

  task automatic send_text(bit with_nl);
    foreach (text_q[i]) push_request(FUNC_CHAR, text_q[i], 15'($urandom));
    if (with_nl) push_request(FUNC_CHAR, CHAR_NL, 15'($urandom));
    text_q.delete();
  endtask

  task automatic begin_record(logic [7:0] tag, logic [23:0] addr, logic [7:0] len);
    text_q.delete();
    text_q.push_back(tag);
    put_hex(addr, 6);
    put_hex(len, 2);
  endtask

  function automatic logic [23:0] pick_addr();
    if ($urandom_range(99) < 85) return 24'($urandom_range(220));
    return 24'($urandom);
  endfunction

  task automatic text_record();
    logic [7:0] len;
    int         pairs, r;
    r = $urandom_range(99);
    if (r < 10) len = 8'd0;
    else if (r < 15) len = 8'($urandom);
    else len = 8'($urandom_range(1, 16));
    r = $urandom_range(99);
    if (r < 15) pairs = $urandom_range(len < 8'd20 ? int'(len) : 20);   // short record
    else if (r < 25) pairs = (len < 8'd20 ? int'(len) : 20) + $urandom_range(1, 4);
    else pairs = (len < 8'd20) ? int'(len) : 20;
    begin_record(CHAR_T, pick_addr(), len);
    repeat (pairs) put_hex(24'($urandom_range(255)), 2);
    if ($urandom_range(9) == 0) put_hex(24'($urandom_range(15)), 1);   // dangling digit
    send_text(1'b1);
  endtask

  task automatic fixup_record();
    logic [7:0] len;
    int         r;
    r = $urandom_range(99);
    if (r < 80) len = 8'($urandom_range(1, 6));
    else if (r < 90) len = 8'd0;
    else len = 8'($urandom_range(7, 255));
    begin_record(CHAR_M, pick_addr(), len);
    send_text(1'b1);
  endtask

  // random bytes, never a newline; length 0 gives an empty line
  task automatic junk_line();
    logic [7:0] b;
    text_q.delete();
    repeat ($urandom_range(12)) begin
      b = 8'($urandom);
      text_q.push_back(b == CHAR_NL ? b + 8'd1 : b);
    end
    send_text(1'b1);
  endtask

  // T record running past the line limit
  task automatic long_record();
    begin_record(CHAR_T, pick_addr(), 8'hFF);
    repeat ($urandom_range(255, 290)) put_hex(24'($urandom_range(15)), 1);
    send_text(1'b1);
  endtask

  task automatic body_line();
    int r;
    r = $urandom_range(99);
    if (r < 55) text_record();
    else if (r < 75) fixup_record();
    else if (r < 80) begin
      begin_record(CHAR_H, pick_addr(), 8'($urandom));   // header while loading
      send_text(1'b1);
    end else if (r < 85) push_request(FUNC_CHAR, CHAR_NL, 15'($urandom));
    else if (r < 90) junk_line();
    else if (r < 94) idle_request();
    else read_probe();
  endtask

  // one object program, mostly well formed, with broken variants mixed in
  task automatic run_program(bit with_long);
    int style;
    style = $urandom_range(99);
    if (style < 8) begin
      // no header: everything after the first line is ignored
      if ($urandom_range(1)) text_record(); else junk_line();
      repeat ($urandom_range(1, 3)) body_line();
      send_eos();
    end else if (style < 12) begin
      // header still open at end of stream
      begin_record(CHAR_H, pick_addr(), 8'($urandom));
      send_text(1'b0);
      send_eos();
    end else begin
      begin_record(CHAR_H, pick_addr(), 8'($urandom));
      send_text(1'b1);
      repeat ($urandom_range(3, 8)) body_line();
      if (with_long) long_record();
      if (style < 20) begin
        // end record missing, or left without its newline
        if ($urandom_range(1)) begin
          begin_record(CHAR_E, pick_addr(), 8'($urandom));
          send_text(1'b0);
        end
      end else begin
        begin_record(CHAR_E, pick_addr(), 8'($urandom));
        send_text(1'b1);
        if ($urandom_range(99) < 25) repeat ($urandom_range(1, 2)) body_line();
      end
      repeat ($urandom_range(2, 6)) read_probe();
      send_eos();
    end
  endtask

  // sender pauses until every outstanding result is back, then a quiet spell
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_base(logic [14:0] v);
    drain();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    cur_base = v;
  endtask

  initial begin
    logic [14:0] base_plan [6];
    int          mark;
    bit          long_done;
    base_plan = '{15'h7FFF, 15'($urandom), 15'h0000, 15'($urandom), 15'h0001, 15'($urandom)};
    long_done = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: store extremes after clearing, an ignored request, and the
    // end-of-stream and first-line outcomes
    push_request(FUNC_READ, 8'h00, 15'h0000);
    push_request(FUNC_READ, 8'hFF, 15'h7FFF);
    idle_request();
    send_eos();                                          // nothing at all: header missing
    push_request(FUNC_CHAR, CHAR_NL, 15'h0000);          // empty first line
    text_q.push_back(CHAR_H);
    send_text(1'b1);                                     // ignored after a bad start
    send_eos();
    text_q.push_back(CHAR_H);
    send_text(1'b1);
    send_eos();                                          // end record missing
    text_q.push_back(CHAR_E);
    send_text(1'b1);                                     // end as first line
    send_eos();
    text_q.push_back(CHAR_H);
    send_text(1'b1);
    text_q.push_back(CHAR_E);
    send_text(1'b0);
    send_eos();                                          // open end line still completes

    // random part: sender/receiver idling swaps after two phases, then stops
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        tx_idle_pct = 46;
        rx_idle_pct = 20;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_base(base_plan[p]);
      mark = items_sent;
      while (items_sent - mark < PHASE_ITEMS) begin
        run_program(!long_done || $urandom_range(99) < 3);
        long_done = 1'b1;
      end
    end

    drain();
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("relocating_object_record_loader_unit_tb OK");
    end else begin
      $display("relocating_object_record_loader_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
